// ----- design/gitq_pkg.sv -----
// ----------------------------------------------------------------------------
// gitq_pkg
// Shared types and constants for the GPIO interrupt handler table and
// event queue: request/response payloads, opcodes, controller states.
// ----------------------------------------------------------------------------
package gitq_pkg;

	localparam int OP_W           = 2;
	localparam int PIN_W          = 5;
	localparam int EV_W           = 4;
	localparam int ID_W           = 5;
	localparam int SLOTS_DEF      = 16;
	localparam int FIFO_DEPTH_DEF = 32;

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_EVENT      = 2'd2,
		OP_POP        = 2'd3
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [PIN_W-1:0] pin;
		logic [EV_W-1:0]  event_bits;
		logic [ID_W-1:0]  handler_id;
	} req_t;

	typedef struct packed {
		logic            ok;
		logic [ID_W-1:0] result_id;
		logic [EV_W-1:0] result_events;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [EV_W-1:0] events;
	} fifo_entry_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_EXEC   = 2'd1,
		S_POP_RD = 2'd2
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic pop_done;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_busy;
		logic pop_hit;
	} dp_status_t;

endpackage

// ----- design/gitq_stream_if.sv -----
// ----------------------------------------------------------------------------
// gitq_stream_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface gitq_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ----- design/gitq_ram.sv -----
// ----------------------------------------------------------------------------
// gitq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gitq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data <= mem_q[raddr];
		end
	end

endmodule

// ----- design/gitq_ctrl.sv -----
// ----------------------------------------------------------------------------
// gitq_ctrl
// Request sequencer: accept a request, execute it once the output register
// is free, and wait in S_POP_RD for queue read data on a pop.
// ----------------------------------------------------------------------------
module gitq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  gitq_pkg::dp_status_t status,
	output gitq_pkg::dp_cmd_t    cmd
);

	import gitq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!status.out_busy) begin
					state_nxt = status.pop_hit ? S_POP_RD : S_IDLE;
				end
			end
			S_POP_RD: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready    = 1'b0;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_EXEC: begin
				cmd.exec = !status.out_busy;
			end
			S_POP_RD: begin
				cmd.pop_done = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	a_pop_rd_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP_RD |=> state_q == S_IDLE)
		else $error("pop read wait lasted more than one cycle");

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !cmd.exec)
		else $error("request executed twice");

	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_EXEC)
		else $error("captured request not executed next");

endmodule

// ----- design/gitq_dp.sv -----
// ----------------------------------------------------------------------------
// gitq_dp
// Datapath: handler slot table with free-slot and match priority encoders,
// ring queue pointers over the event RAM, and the response register.
// ----------------------------------------------------------------------------
module gitq_dp #(
	parameter int SLOTS      = gitq_pkg::SLOTS_DEF,
	parameter int FIFO_DEPTH = gitq_pkg::FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gitq_pkg::req_t       req_payload,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output gitq_pkg::rsp_t       rsp_payload,
	input  gitq_pkg::dp_cmd_t    cmd,
	output gitq_pkg::dp_status_t status
);

	import gitq_pkg::*;

	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int ENTRY_W = $bits(fifo_entry_t);

	req_t             req_q;
	logic [SLOTS-1:0] slot_en_q;
	logic [PIN_W-1:0] slot_pin_q  [SLOTS];
	logic [EV_W-1:0]  slot_mask_q [SLOTS];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             out_valid_q;
	rsp_t             out_q;

	op_t              op;
	logic [SLOTS-1:0] free_vec;
	logic [SLOTS-1:0] free_oh;
	logic [SLOTS-1:0] match_vec;
	logic [SLOTS-1:0] match_oh;
	logic [SLOTS-1:0] unreg_vec;
	logic [ID_W-1:0]  free_id;
	logic [ID_W-1:0]  match_id;
	logic [PTR_W-1:0] wr_ptr_nxt;
	logic [PTR_W-1:0] rd_ptr_nxt;
	logic             q_empty;
	logic             q_full;
	logic             do_reg;
	logic             do_unreg;
	logic             do_push;
	logic             do_pop;
	rsp_t             exec_rsp;
	fifo_entry_t      push_entry;
	fifo_entry_t      pop_entry;
	logic [ENTRY_W-1:0] ram_rdata;

	// Capture the accepted request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_payload;
		end
	end

	assign op = op_t'(req_q.operation);

	// Per-slot compares
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i]  = !slot_en_q[i];
			match_vec[i] = slot_en_q[i] && (slot_pin_q[i] == req_q.pin) &&
				(|(slot_mask_q[i] & req_q.event_bits));
			unreg_vec[i] = slot_en_q[i] && (req_q.handler_id == ID_W'(i + 1));
		end
	end

	// Isolate lowest set bit, then encode to a 1-based ID
	assign free_oh  = free_vec & (~free_vec + SLOTS'(1));
	assign match_oh = match_vec & (~match_vec + SLOTS'(1));

	always_comb begin
		free_id  = '0;
		match_id = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (free_oh[i]) begin
				free_id = free_id | ID_W'(i + 1);
			end
			if (match_oh[i]) begin
				match_id = match_id | ID_W'(i + 1);
			end
		end
	end

	// Queue pointer arithmetic
	assign wr_ptr_nxt = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_ptr_nxt = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
	assign q_empty    = (wr_ptr_q == rd_ptr_q);
	assign q_full     = (wr_ptr_nxt == rd_ptr_q);

	// Decode the operation into actions and an immediate response
	always_comb begin
		exec_rsp = '0;
		do_reg   = 1'b0;
		do_unreg = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		unique case (op)
			OP_REGISTER: begin
				if (|free_vec) begin
					do_reg             = 1'b1;
					exec_rsp.ok        = 1'b1;
					exec_rsp.result_id = free_id;
				end
			end
			OP_UNREGISTER: begin
				if (|unreg_vec) begin
					do_unreg    = 1'b1;
					exec_rsp.ok = 1'b1;
				end
			end
			OP_EVENT: begin
				if ((|match_vec) && !q_full) begin
					do_push     = 1'b1;
					exec_rsp.ok = 1'b1;
				end
			end
			OP_POP: begin
				do_pop = !q_empty;
			end
			default: begin
				do_pop = 1'b0;
			end
		endcase
	end

	// Slot enables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_en_q <= '0;
		end else if (cmd.exec) begin
			if (do_reg) begin
				slot_en_q <= slot_en_q | free_oh;
			end else if (do_unreg) begin
				slot_en_q <= slot_en_q & ~unreg_vec;
			end
		end
	end

	// Slot pin and mask; disabled slots are never looked at
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (cmd.exec && do_reg && free_oh[i]) begin
				slot_pin_q[i]  <= req_q.pin;
				slot_mask_q[i] <= req_q.event_bits;
			end
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (cmd.exec) begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
		end
	end

	assign push_entry.id     = match_id;
	assign push_entry.events = req_q.event_bits;

	gitq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FIFO_DEPTH)
	) u_event_ram (
		.clk     (clk),
		.we      (cmd.exec && do_push),
		.waddr   (wr_ptr_q),
		.wdata   (push_entry),
		.re      (cmd.exec && do_pop),
		.raddr   (rd_ptr_q),
		.rd_data (ram_rdata)
	);

	assign pop_entry = fifo_entry_t'(ram_rdata);

	// Response register: load on execute (but for a non-empty pop) or on pop completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && !do_pop) || cmd.pop_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !do_pop) begin
			out_q <= exec_rsp;
		end else if (cmd.pop_done) begin
			out_q.ok            <= 1'b1;
			out_q.result_id     <= pop_entry.id;
			out_q.result_events <= pop_entry.events;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_payload     = out_q;
	assign status.out_busy = out_valid_q && !rsp_ready;
	assign status.pop_hit  = (op == OP_POP) && !q_empty;

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.ok |-> out_q.result_id == '0 && out_q.result_events == '0)
		else $error("failed response carries nonzero fields");

	a_pop_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_done |-> $past(cmd.exec && do_pop))
		else $error("pop completion without a queue read");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= PTR_W'(FIFO_DEPTH - 1) && rd_ptr_q <= PTR_W'(FIFO_DEPTH - 1))
		else $error("queue pointer out of range");

	a_reg_takes_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && do_reg |=> $countones(slot_en_q) == $past($countones(slot_en_q)) + 1)
		else $error("register did not enable exactly one slot");

endmodule

// ----- design/gpio_irq_event_table_queue.sv -----
// Response path: the request is captured, executed in S_EXEC and loaded into the
// response register; a non-empty pop also waits in S_POP_RD (registered event RAM read).
// Throughput: a new request is accepted only after the last one has executed, as set by
// the controller; a waiting response stalls execution and so the next acceptance.
// Reset: arst_n clears all handler slots, both queue pointers and the response register.
// ----------------------------------------------------------------------------
// gpio_irq_event_table_queue
// Pin interrupt handler table with a ring queue of captured events:
// register, unregister, pin event match/enqueue, and pop.
// ----------------------------------------------------------------------------
module gpio_irq_event_table_queue #(
	parameter int SLOTS      = gitq_pkg::SLOTS_DEF,
	parameter int FIFO_DEPTH = gitq_pkg::FIFO_DEPTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	gitq_stream_if.sink   req,
	gitq_stream_if.source rsp
);

	import gitq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       req_ready;
	logic       rsp_valid;
	rsp_t       rsp_payload;
	req_t       req_payload;

	assign req_payload = req_t'(req.payload);
	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = rsp_payload;

	gitq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gitq_dp #(
		.SLOTS      (SLOTS),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_payload (req_payload),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp_valid),
		.rsp_payload (rsp_payload),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GPIO handler table and event queue. A directed
// table of requests runs first, then a pass that fills the table and
// overflows the event ring under a long response hold-off. Random traffic
// follows under several sender idle and receiver stall patterns. Every
// response is compared field by field against its directed row's expected
// value or an in-bench model of the table and the ring.
// ----------------------------------------------------------------------------
module tb_top;
	import gitq_pkg::*;

	localparam int SLOTS        = SLOTS_DEF;
	localparam int DEPTH        = FIFO_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1744;
	localparam int PHASES       = 4;
	localparam int QUIET_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 10;
	localparam int HOLD_CYCLES  = 80;
	localparam int PRINT_LIMIT  = 100;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	gitq_stream_if #(.T(req_t)) req_if ();
	gitq_stream_if #(.T(rsp_t)) rsp_if ();

	gpio_irq_event_table_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Model of the handler table and the event ring
	bit               slot_on     [SLOTS];
	logic [PIN_W-1:0] slot_pin_m  [SLOTS];
	logic [EV_W-1:0]  slot_mask_m [SLOTS];
	fifo_entry_t      event_ring  [DEPTH];
	int unsigned      ring_rd;
	int unsigned      ring_wr;

	rsp_t        answers_due [$];
	dir_row_t    dir_rows    [$];
	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned rsp_hold_ask;
	int unsigned hold_reqs;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned mismatches;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_t mk_req(input op_t op, input int pin, input int ev, input int id);
		req_t r;
		r.operation  = op;
		r.pin        = pin[PIN_W-1:0];
		r.event_bits = ev[EV_W-1:0];
		r.handler_id = id[ID_W-1:0];
		return r;
	endfunction

	function automatic void add_row(input op_t op, input int pin, input int ev, input int id,
		input bit typed, input int ok, input int rid, input int rev);
		dir_row_t row;
		row.req                = mk_req(op, pin, ev, id);
		row.typed              = typed;
		row.want.ok            = ok[0];
		row.want.result_id     = rid[ID_W-1:0];
		row.want.result_events = rev[EV_W-1:0];
		dir_rows.push_back(row);
	endfunction

	// Apply one request to the table and ring; return the response it causes
	function automatic rsp_t apply_irq_request(input req_t r);
		rsp_t        a;
		int unsigned nxt;
		int          hid;
		bit          done;
		a    = '0;
		done = 1'b0;
		hid  = int'(r.handler_id);
		case (r.operation)
			OP_REGISTER: begin
				// take the lowest free slot
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && !slot_on[i]) begin
						slot_on[i]     = 1'b1;
						slot_pin_m[i]  = r.pin;
						slot_mask_m[i] = r.event_bits;
						a.ok           = 1'b1;
						a.result_id    = ID_W'(i + 1);
						done           = 1'b1;
					end
				end
			end
			OP_UNREGISTER: begin
				if (hid >= 1 && hid <= SLOTS && slot_on[hid - 1]) begin
					slot_on[hid - 1]     = 1'b0;
					slot_pin_m[hid - 1]  = '0;
					slot_mask_m[hid - 1] = '0;
					a.ok                 = 1'b1;
				end
			end
			OP_EVENT: begin
				// lowest enabled handler on this pin with an overlapping mask
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && slot_on[i] && slot_pin_m[i] == r.pin &&
						(slot_mask_m[i] & r.event_bits) != '0) begin
						done = 1'b1;
						nxt  = (ring_wr + 1) % DEPTH;
						// drop the event when the ring is full
						if (nxt != ring_rd) begin
							event_ring[ring_wr].id     = ID_W'(i + 1);
							event_ring[ring_wr].events = r.event_bits;
							ring_wr                    = nxt;
							a.ok                       = 1'b1;
						end
					end
				end
			end
			OP_POP: begin
				if (ring_rd != ring_wr) begin
					a.ok            = 1'b1;
					a.result_id     = event_ring[ring_rd].id;
					a.result_events = event_ring[ring_rd].events;
					ring_rd         = (ring_rd + 1) % DEPTH;
				end
			end
		endcase
		return a;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic check_answer(input rsp_t got);
		rsp_t want;
		if (answers_due.size() == 0) begin
			report_mismatch("response with no request pending", 32'(got), 32'd0);
		end else begin
			want = answers_due.pop_front();
			if (got.ok !== want.ok)
				report_mismatch("ok", 32'(got.ok), 32'(want.ok));
			if (got.result_id !== want.result_id)
				report_mismatch("result_id", 32'(got.result_id), 32'(want.result_id));
			if (got.result_events !== want.result_events)
				report_mismatch("result_events", 32'(got.result_events),
					32'(want.result_events));
		end
	endtask

	// Offer one request at the current idle rate; log its expected response on accept
	task automatic send_request(input req_t r, input bit typed, input rsp_t want);
		rsp_t p;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
		p = apply_irq_request(r);
		answers_due.push_back(typed ? want : p);
	endtask

	// Hold off new requests until every pending response has come back
	task automatic drain_answers();
		req_if.valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	// Check responses and drive ready: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready)
			check_answer(rsp_if.payload);
		if (hold_reqs != hold_seen) begin
			hold_left = rsp_hold_ask;
			hold_seen = hold_reqs;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// End the run when no request or response moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		dir_row_t    row;
		req_t        r;
		int unsigned pick;
		int unsigned idle_mix  [PHASES];
		int unsigned stall_mix [PHASES];
		arst_n         <= 1'b0;
		req_if.valid   <= 1'b0;
		req_if.payload <= '0;
		send_idle_pct  = 0;
		rsp_stall_pct  = 0;
		rsp_hold_ask   = 0;
		mismatches     = 0;
		ring_rd        = 0;
		ring_wr        = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_on[i]     = 1'b0;
			slot_pin_m[i]  = '0;
			slot_mask_m[i] = '0;
		end
		idle_mix  = '{0, 87, 0, 9};
		stall_mix = '{0, 0, 87, 9};

		//      op             pin  ev  id  typed ok  id  ev
		// empty queue, then invalid IDs: zero, disabled, above the table, maximum
		add_row(OP_POP,          0,  0,  0,  1,   0,  0,  0);
		add_row(OP_UNREGISTER,   0,  0,  0,  1,   0,  0,  0);
		add_row(OP_UNREGISTER,   0,  0,  1,  1,   0,  0,  0);
		add_row(OP_UNREGISTER,   0,  0, 17,  1,   0,  0,  0);
		add_row(OP_UNREGISTER,  31, 15, 31,  1,   0,  0,  0);
		// event with no handler registered
		add_row(OP_EVENT,        0, 15,  0,  1,   0,  0,  0);
		add_row(OP_REGISTER,    31, 15,  0,  1,   1,  1,  0);
		// empty mask takes a slot but never matches
		add_row(OP_REGISTER,     0,  0,  0,  1,   1,  2,  0);
		add_row(OP_EVENT,        0, 15,  0,  1,   0,  0,  0);
		add_row(OP_EVENT,       31,  8,  0,  1,   1,  0,  0);
		add_row(OP_REGISTER,     5,  1,  0,  1,   1,  3,  0);
		// pin matches, mask does not overlap
		add_row(OP_EVENT,        5,  6,  0,  1,   0,  0,  0);
		add_row(OP_EVENT,        5,  1,  0,  1,   1,  0,  0);
		add_row(OP_REGISTER,     5,  2,  0,  1,   1,  4,  0);
		// two handlers match, the lower one wins
		add_row(OP_EVENT,        5,  3,  0,  0,   0,  0,  0);
		add_row(OP_POP,          0,  0,  0,  1,   1,  1,  8);
		add_row(OP_POP,          0,  0,  0,  1,   1,  3,  1);
		add_row(OP_POP,          0,  0,  0,  0,   0,  0,  0);
		add_row(OP_POP,          0,  0,  0,  1,   0,  0,  0);
		// freed slot is reused first
		add_row(OP_UNREGISTER,   0,  0,  1,  1,   1,  0,  0);
		add_row(OP_REGISTER,    10, 10,  0,  1,   1,  1,  0);
		add_row(OP_EVENT,       10,  5,  0,  1,   0,  0,  0);
		add_row(OP_UNREGISTER,   0,  0,  3,  1,   1,  0,  0);
		add_row(OP_EVENT,        5,  3,  0,  0,   0,  0,  0);
		add_row(OP_POP,         31, 15, 31,  0,   0,  0,  0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			send_request(row.req, row.typed, row.want);
		end
		drain_answers();

		// Fill the table past full, then release the top ID
		for (int i = 0; i < 14; i++)
			send_request(mk_req(OP_REGISTER, 31, 15, 0), 1'b0, '0);
		send_request(mk_req(OP_UNREGISTER, 0, 0, SLOTS), 1'b0, '0);
		drain_answers();

		// Overflow the ring while responses are held off
		rsp_hold_ask = HOLD_CYCLES;
		hold_reqs++;
		for (int i = 0; i < DEPTH + 1; i++)
			send_request(mk_req(OP_EVENT, 31, $urandom_range(1, 15), 0), 1'b0, '0);
		drain_answers();
		for (int i = 0; i < DEPTH + 1; i++)
			send_request(mk_req(OP_POP, $urandom, $urandom, $urandom), 1'b0, '0);
		drain_answers();

		// Random traffic, one idle/stall pattern per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = idle_mix[ph];
			rsp_stall_pct = stall_mix[ph];
			rsp_hold_ask  = HOLD_CYCLES / 2;
			hold_reqs++;
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				// keep pins mostly in a small set so events find handlers
				r.pin        = ($urandom_range(7) == 0) ? PIN_W'($urandom)
					: PIN_W'($urandom_range(3));
				r.event_bits = EV_W'($urandom);
				r.handler_id = ($urandom_range(7) == 0) ? ID_W'($urandom)
					: ID_W'($urandom_range(1, SLOTS));
				pick = $urandom_range(99);
				if (pick < 22)
					r.operation = OP_REGISTER;
				else if (pick < 40)
					r.operation = OP_UNREGISTER;
				else if (pick < 75)
					r.operation = OP_EVENT;
				else
					r.operation = OP_POP;
				send_request(r, 1'b0, '0);
			end
			drain_answers();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
